FILE: src/eoh_pkg.sv
// Package for the ellipse outline hit test unit.
// Holds the register codes, the configuration record and fixed field widths.
// No dependencies.
package eoh_pkg;

  localparam int COORD_W   = 16;
  localparam int TOL_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int EXT_W     = 19;
  localparam int SIDE_W    = 2 * EXT_W + 1 + COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LEFT   = 3'd0,
    REG_BOX_TOP    = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_HIT_TOL    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [TOL_W-1:0]   hit_tolerance;
  } cfg_t;

endpackage

FILE: src/eoh_isqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a valid bit and a sideband word alongside the root.
// No package dependencies.
module eoh_isqrt_pipe #(
  parameter int ROOT_W = 24,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  logic                vld_r  [ROOT_W];
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W];
  logic [ROOT_W+1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [SIDE_W-1:0]   side_r [ROOT_W];

  logic                pv_vld  [ROOT_W];
  logic [2*ROOT_W-1:0] pv_rad  [ROOT_W];
  logic [ROOT_W+1:0]   pv_rem  [ROOT_W];
  logic [ROOT_W-1:0]   pv_root [ROOT_W];
  logic [SIDE_W-1:0]   pv_side [ROOT_W];

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic              ge;
      logic [ROOT_W+1:0] rem_nxt;
      logic [ROOT_W-1:0] root_nxt;

      if (i == 0) begin : g_first
        assign pv_vld[i]  = in_vld;
        assign pv_rad[i]  = in_rad;
        assign pv_rem[i]  = '0;
        assign pv_root[i] = '0;
        assign pv_side[i] = in_side;
      end else begin : g_next
        assign pv_vld[i]  = vld_r[i-1];
        assign pv_rad[i]  = rad_r[i-1];
        assign pv_rem[i]  = rem_r[i-1];
        assign pv_root[i] = root_r[i-1];
        assign pv_side[i] = side_r[i-1];
      end

      always_comb begin
        rem_sh   = {pv_rem[i][ROOT_W-1:0], pv_rad[i][2*ROOT_W-1 -: 2]};
        trial    = {pv_root[i], 2'b01};
        ge       = (rem_sh >= trial);
        rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {pv_root[i][ROOT_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= pv_vld[i];
        end
      end

      always_ff @(posedge clk) begin
        rad_r[i]  <= pv_rad[i] << 2;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        side_r[i] <= pv_side[i];
      end
    end
  endgenerate

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

FILE: src/eoh_prep.sv
// Front stages: doubled offsets of the point from the centre and |w^2 - h^2|.
// Depends on eoh_pkg for widths and the configuration record.
module eoh_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [eoh_pkg::COORD_W-1:0]  point_x,
  input  logic [eoh_pkg::COORD_W-1:0]  point_y,
  input  eoh_pkg::cfg_t                cfg,
  output logic                         out_vld,
  output logic [2*eoh_pkg::COORD_W-1:0] out_diff,
  output logic [eoh_pkg::EXT_W-1:0]    out_ex,
  output logic [eoh_pkg::EXT_W-1:0]    out_ey,
  output logic                         out_wmaj,
  output logic [eoh_pkg::COORD_W-1:0]  out_hmaj
);

  localparam int CW = eoh_pkg::COORD_W;
  localparam int XW = eoh_pkg::EXT_W;

  logic [XW-1:0]   px_e, py_e, lx_e, ty_e, ex_nxt, ey_nxt;

  logic            a_vld_r;
  logic [2*CW-1:0] ww_r, hh_r;
  logic [XW-1:0]   a_ex_r, a_ey_r;
  logic [CW-1:0]   a_hmaj_r;

  logic            b_vld_r;
  logic [2*CW-1:0] diff_r;
  logic [XW-1:0]   b_ex_r, b_ey_r;
  logic            b_wmaj_r;
  logic [CW-1:0]   b_hmaj_r;

  always_comb begin
    px_e   = {{(XW-CW){point_x[CW-1]}}, point_x};
    py_e   = {{(XW-CW){point_y[CW-1]}}, point_y};
    lx_e   = {{(XW-CW){cfg.box_left[CW-1]}}, cfg.box_left};
    ty_e   = {{(XW-CW){cfg.box_top[CW-1]}}, cfg.box_top};
    ex_nxt = (px_e << 1) - (lx_e << 1) - {{(XW-CW){1'b0}}, cfg.box_width};
    ey_nxt = (py_e << 1) - (ty_e << 1) - {{(XW-CW){1'b0}}, cfg.box_height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ww_r     <= cfg.box_width * cfg.box_width;
    hh_r     <= cfg.box_height * cfg.box_height;
    a_ex_r   <= ex_nxt;
    a_ey_r   <= ey_nxt;
    a_hmaj_r <= (cfg.box_width >= cfg.box_height) ? cfg.box_width : cfg.box_height;
    diff_r   <= (ww_r >= hh_r) ? (ww_r - hh_r) : (hh_r - ww_r);
    b_ex_r   <= a_ex_r;
    b_ey_r   <= a_ey_r;
    b_wmaj_r <= (ww_r >= hh_r);
    b_hmaj_r <= a_hmaj_r;
  end

  assign out_vld  = b_vld_r;
  assign out_diff = diff_r;
  assign out_ex   = b_ex_r;
  assign out_ey   = b_ey_r;
  assign out_wmaj = b_wmaj_r;
  assign out_hmaj = b_hmaj_r;

endmodule

FILE: src/eoh_square.sv
// Focal offset vectors, their squares in split partial products and the two
// sums of squares. Depends on eoh_pkg for widths.
module eoh_square #(
  parameter int FRAC_W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [eoh_pkg::COORD_W+FRAC_W-1:0] in_d,
  input  logic [eoh_pkg::EXT_W-1:0]       in_ex,
  input  logic [eoh_pkg::EXT_W-1:0]       in_ey,
  input  logic                            in_wmaj,
  input  logic [eoh_pkg::COORD_W-1:0]     in_hmaj,
  output logic                            out_vld,
  output logic [2*(19+FRAC_W)-1:0]        out_rad1,
  output logic [2*(19+FRAC_W)-1:0]        out_rad2,
  output logic [eoh_pkg::COORD_W-1:0]     out_hmaj
);

  localparam int EW = eoh_pkg::EXT_W;
  localparam int CW = eoh_pkg::COORD_W;
  localparam int MW = 18 + FRAC_W;
  localparam int XW = MW + 2;
  localparam int RV = MW + 1;
  localparam int LW = (MW + 1) / 2;
  localparam int HW = MW - LW;

  logic [XW-1:0] dxc, dyc, dv;
  logic [XW-1:0] vec [4];
  logic [MW-1:0] mag [4];

  logic          c_vld_r, d_vld_r, e_vld_r, f_vld_r;
  logic [CW-1:0] c_hmaj_r, d_hmaj_r, e_hmaj_r, f_hmaj_r;
  logic [MW-1:0] c_mag_r [4];
  logic [2*HW-1:0]    pp_hh_r [4];
  logic [HW+LW-1:0]   pp_hl_r [4];
  logic [2*LW-1:0]    pp_ll_r [4];
  logic [2*MW-1:0]    sq_r [4];
  logic [2*RV-1:0]    rad1_r, rad2_r;

  always_comb begin
    dxc = {{(XW-EW){in_ex[EW-1]}}, in_ex} << FRAC_W;
    dyc = {{(XW-EW){in_ey[EW-1]}}, in_ey} << FRAC_W;
    dv  = {{(XW-CW-FRAC_W){1'b0}}, in_d};
    if (in_wmaj) begin
      vec[0] = dxc + dv;
      vec[1] = dyc;
      vec[2] = dxc - dv;
      vec[3] = dyc;
    end else begin
      vec[0] = dxc;
      vec[1] = dyc + dv;
      vec[2] = dxc;
      vec[3] = dyc - dv;
    end
    for (int k = 0; k < 4; k++) begin
      mag[k] = vec[k][XW-1] ? (MW)'(-vec[k]) : vec[k][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else begin
      c_vld_r <= in_vld;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_hmaj_r <= in_hmaj;
    d_hmaj_r <= c_hmaj_r;
    e_hmaj_r <= d_hmaj_r;
    f_hmaj_r <= e_hmaj_r;
    for (int k = 0; k < 4; k++) begin
      c_mag_r[k] <= mag[k];
      pp_hh_r[k] <= c_mag_r[k][MW-1:LW] * c_mag_r[k][MW-1:LW];
      pp_hl_r[k] <= c_mag_r[k][MW-1:LW] * c_mag_r[k][LW-1:0];
      pp_ll_r[k] <= c_mag_r[k][LW-1:0] * c_mag_r[k][LW-1:0];
      sq_r[k]    <= ((2*MW)'(pp_hh_r[k]) << (2*LW))
                  + ((2*MW)'(pp_hl_r[k]) << (LW+1))
                  + (2*MW)'(pp_ll_r[k]);
    end
    rad1_r <= (2*RV)'(sq_r[0]) + (2*RV)'(sq_r[1]);
    rad2_r <= (2*RV)'(sq_r[2]) + (2*RV)'(sq_r[3]);
  end

  assign out_vld  = f_vld_r;
  assign out_rad1 = rad1_r;
  assign out_rad2 = rad2_r;
  assign out_hmaj = f_hmaj_r;

endmodule

FILE: src/ellipse_outline_hit_test_unit.sv
// Top level of the ellipse outline hit test unit.
// Depends on eoh_pkg, eoh_prep, eoh_isqrt_pipe and eoh_square.
//
// Usage: the ellipse is set through the configuration port (cfg_wr_en,
// cfg_index, cfg_data) as a bounding box and a tolerance, written while no
// request is in flight. A request is a point on in_point_x and in_point_y,
// taken at a clock edge where start is high and busy is low. Busy is never
// raised, so a new request may be issued in every cycle.
// Each request yields one result: out_strobe is high for one cycle and out_hit
// then tells whether the point lies in the tolerance band of the outline.
// Throughput is one request per cycle. The depth is set by the two bit-serial
// square root pipelines, one stage per root bit, for the focal offset and for
// the focal distances. Results are in request order. The receiver cannot stall
// the results, and none is needed: every stage advances in every cycle.
// A synchronous reset empties the pipeline and sets the box to zero and the
// tolerance to two pixels.
module ellipse_outline_hit_test_unit #(
  parameter int SQRT_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [eoh_pkg::COORD_W-1:0]   in_point_x,
  input  logic [eoh_pkg::COORD_W-1:0]   in_point_y,
  output logic                          out_strobe,
  output logic                          out_hit,
  input  logic                          cfg_wr_en,
  input  logic [eoh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eoh_pkg::COORD_W-1:0]   cfg_data
);

  localparam int F   = SQRT_FRAC_BITS;
  localparam int CW  = eoh_pkg::COORD_W;
  localparam int TW  = eoh_pkg::TOL_W;
  localparam int EW  = eoh_pkg::EXT_W;
  localparam int SW  = eoh_pkg::SIDE_W;
  localparam int RD  = CW + F;
  localparam int MW  = 18 + F;
  localparam int RV  = MW + 1;
  localparam int SUW = MW + 2;
  localparam int LAT = 43 + 2 * F;

  eoh_pkg::cfg_t cfg_r;

  logic            accept;
  logic            p_vld;
  logic [2*CW-1:0] p_diff;
  logic [EW-1:0]   p_ex, p_ey;
  logic            p_wmaj;
  logic [CW-1:0]   p_hmaj;

  logic            d_vld;
  logic [RD-1:0]   d_root;
  logic [SW-1:0]   d_side;

  logic            s_vld;
  logic [2*RV-1:0] s_rad1, s_rad2;
  logic [CW-1:0]   s_hmaj;

  logic            v1_vld, v2_vld;
  logic [RV-1:0]   v1_root, v2_root;
  logic [CW/2-1:0] v1_side, v2_side;

  logic            g_vld_r;
  logic [SUW-1:0]  sum_r;
  logic [CW-1:0]   g_hmaj_r;

  logic [17:0]     up_px, lo_px;
  logic [16:0]     lo_half;
  logic [SUW-1:0]  upper, lower;
  logic            lower_neg;
  logic            out_strobe_r, out_hit_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_left      <= '0;
      cfg_r.box_top       <= '0;
      cfg_r.box_width     <= '0;
      cfg_r.box_height    <= '0;
      cfg_r.hit_tolerance <= TW'(2);
    end else if (cfg_wr_en) begin
      unique case (eoh_pkg::reg_idx_t'(cfg_index))
        eoh_pkg::REG_BOX_LEFT:   cfg_r.box_left      <= cfg_data;
        eoh_pkg::REG_BOX_TOP:    cfg_r.box_top       <= cfg_data;
        eoh_pkg::REG_BOX_WIDTH:  cfg_r.box_width     <= cfg_data;
        eoh_pkg::REG_BOX_HEIGHT: cfg_r.box_height    <= cfg_data;
        eoh_pkg::REG_HIT_TOL:    cfg_r.hit_tolerance <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  eoh_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .cfg      (cfg_r),
    .out_vld  (p_vld),
    .out_diff (p_diff),
    .out_ex   (p_ex),
    .out_ey   (p_ey),
    .out_wmaj (p_wmaj),
    .out_hmaj (p_hmaj)
  );

  eoh_isqrt_pipe #(.ROOT_W(RD), .SIDE_W(SW)) u_focal_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p_vld),
    .in_rad   ((2*RD)'(p_diff) << (2*F)),
    .in_side  ({p_ex, p_ey, p_wmaj, p_hmaj}),
    .out_vld  (d_vld),
    .out_root (d_root),
    .out_side (d_side)
  );

  eoh_square #(.FRAC_W(F)) u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d_vld),
    .in_d     (d_root),
    .in_ex    (d_side[SW-1 -: EW]),
    .in_ey    (d_side[SW-EW-1 -: EW]),
    .in_wmaj  (d_side[CW]),
    .in_hmaj  (d_side[CW-1:0]),
    .out_vld  (s_vld),
    .out_rad1 (s_rad1),
    .out_rad2 (s_rad2),
    .out_hmaj (s_hmaj)
  );

  eoh_isqrt_pipe #(.ROOT_W(RV), .SIDE_W(CW/2)) u_dist1_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s_vld),
    .in_rad   (s_rad1),
    .in_side  (s_hmaj[CW-1:CW/2]),
    .out_vld  (v1_vld),
    .out_root (v1_root),
    .out_side (v1_side)
  );

  eoh_isqrt_pipe #(.ROOT_W(RV), .SIDE_W(CW/2)) u_dist2_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s_vld),
    .in_rad   (s_rad2),
    .in_side  (s_hmaj[CW/2-1:0]),
    .out_vld  (v2_vld),
    .out_root (v2_root),
    .out_side (v2_side)
  );

  always_comb begin
    up_px     = ({2'b00, g_hmaj_r} << 1) + {8'd0, cfg_r.hit_tolerance, 2'b00};
    lower_neg = (g_hmaj_r < {{(CW-TW){1'b0}}, cfg_r.hit_tolerance});
    lo_half   = {1'b0, g_hmaj_r} - {{(17-TW){1'b0}}, cfg_r.hit_tolerance};
    lo_px     = {lo_half, 1'b0};
    upper     = SUW'(up_px) << F;
    lower     = SUW'(lo_px) << F;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      g_vld_r      <= v1_vld && v2_vld;
      out_strobe_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= SUW'(v1_root) + SUW'(v2_root);
    g_hmaj_r  <= {v1_side, v2_side};
    out_hit_r <= g_vld_r && (sum_r <= upper) && (lower_neg || (sum_r >= lower));
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r && out_strobe_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("request did not produce a result after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result produced without a matching request");

  a_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    v1_vld == v2_vld)
    else $error("focal distance pipelines out of step");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for ellipse_outline_hit_test_unit.
// Drives configuration writes and point requests from a plan queue, predicts
// each hit from the focal distance sum and checks results in order; needs eoh_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SQRT_FRAC_BITS = 8;
  localparam int LATENCY = 43 + 2 * SQRT_FRAC_BITS;
  localparam logic [eoh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam real PI = 3.14159265358979;

  typedef struct {
    bit                            is_cfg;
    logic [eoh_pkg::CFG_IDX_W-1:0] idx;
    logic [eoh_pkg::COORD_W-1:0]   data;
    logic [eoh_pkg::COORD_W-1:0]   px;
    logic [eoh_pkg::COORD_W-1:0]   py;
  } plan_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [eoh_pkg::COORD_W-1:0] in_point_x = '0;
  logic [eoh_pkg::COORD_W-1:0] in_point_y = '0;
  logic out_strobe;
  logic out_hit;
  logic cfg_wr_en = 0;
  logic [eoh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [eoh_pkg::COORD_W-1:0] cfg_data = '0;

  ellipse_outline_hit_test_unit #(.SQRT_FRAC_BITS(SQRT_FRAC_BITS)) dut (.*);

  always #1 clk = ~clk;

  plan_t plan_q[$];
  bit    hit_q[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    hits_seen = 0;
  int    writes_done = 0;

  // configuration as the block holds it
  logic signed [15:0] m_left = 0, m_top = 0;
  logic [15:0] m_width = 0, m_height = 0;
  logic [7:0]  m_tol = 2;

  // configuration as planned while filling the plan queue
  int p_left = 0, p_top = 0, p_width = 0, p_height = 0, p_tol = 2;

  function automatic longint floor_sqrt(longint unsigned v);
    logic [127:0] r, c;
    r = 0;
    for (int b = 36; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= {64'd0, v}) r = c;
    end
    return longint'(r);
  endfunction

  function automatic bit hit_predict(logic signed [15:0] px, logic signed [15:0] py);
    longint one, w, h, diff, d, dxc, dyc, ax1, ay1, ax2, ay2, hmaj, sum, upper, lower;
    one = 1 << SQRT_FRAC_BITS;
    w = m_width;
    h = m_height;
    diff = (w * w >= h * h) ? w * w - h * h : h * h - w * w;
    d = floor_sqrt(diff * one * one);
    dxc = (2 * longint'(px) - (2 * longint'(m_left) + w)) * one;
    dyc = (2 * longint'(py) - (2 * longint'(m_top) + h)) * one;
    if (w >= h) begin
      hmaj = w;
      ax1 = dxc + d; ay1 = dyc; ax2 = dxc - d; ay2 = dyc;
    end else begin
      hmaj = h;
      ax1 = dxc; ay1 = dyc + d; ax2 = dxc; ay2 = dyc - d;
    end
    sum = floor_sqrt(ax1 * ax1 + ay1 * ay1) + floor_sqrt(ax2 * ax2 + ay2 * ay2);
    upper = (2 * hmaj + 4 * longint'(m_tol)) * one;
    lower = (2 * hmaj - 2 * longint'(m_tol)) * one;
    return sum <= upper && (lower < 0 || sum >= lower);
  endfunction

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic plan_write(logic [eoh_pkg::CFG_IDX_W-1:0] idx, int value);
    plan_t p;
    p.is_cfg = 1; p.idx = idx; p.data = value[15:0]; p.px = '0; p.py = '0;
    plan_q.push_back(p);
    case (idx)
      eoh_pkg::REG_BOX_LEFT:   p_left = $signed(value[15:0]);
      eoh_pkg::REG_BOX_TOP:    p_top = $signed(value[15:0]);
      eoh_pkg::REG_BOX_WIDTH:  p_width = value[15:0];
      eoh_pkg::REG_BOX_HEIGHT: p_height = value[15:0];
      eoh_pkg::REG_HIT_TOL:    p_tol = value[7:0];
      default: ;
    endcase
  endtask

  task automatic plan_box(int l, int t, int w, int h, int tol);
    plan_write(eoh_pkg::REG_BOX_LEFT, l);
    plan_write(eoh_pkg::REG_BOX_TOP, t);
    plan_write(eoh_pkg::REG_BOX_WIDTH, w);
    plan_write(eoh_pkg::REG_BOX_HEIGHT, h);
    plan_write(eoh_pkg::REG_HIT_TOL, tol);
  endtask

  task automatic plan_point(int x, int y);
    plan_t p;
    p.is_cfg = 0; p.idx = '0; p.data = '0;
    p.px = clamp16(x); p.py = clamp16(y);
    plan_q.push_back(p);
  endtask

  // A point near the outline of the planned ellipse, jittered around the band.
  task automatic plan_near_outline();
    real a, b, ang;
    int jit;
    a = p_width / 2.0;
    b = p_height / 2.0;
    ang = $urandom_range(0, 3599) * PI / 1800.0;
    jit = p_tol + 2;
    plan_point($rtoi(p_left + a + a * $cos(ang)) + $urandom_range(0, 2 * jit) - jit,
               $rtoi(p_top + b + b * $sin(ang)) + $urandom_range(0, 2 * jit) - jit);
  endtask

  task automatic plan_random_phase(int count);
    int w, h;
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom_range(0, 65535); h = $urandom_range(0, 65535);
    end else begin
      w = $urandom_range(0, 300); h = $urandom_range(0, 300);
    end
    plan_box($signed(16'($urandom)), $signed(16'($urandom)), w, h,
             $urandom_range(0, 255) >> $urandom_range(0, 7));
    for (int i = 0; i < count; i++)
      if ($urandom_range(0, 9) < 7) plan_near_outline();
      else plan_point($signed(16'($urandom)), $signed(16'($urandom)));
  endtask

  // Directed part: degenerate reset box, a small ellipse, an unused register and the extremes; then random phases.
  initial begin
    plan_point(0, 0);
    plan_point(1, 1);
    plan_point(-32768, 32767);
    plan_box(10, 20, 40, 20, 2);
    plan_write(REG_UNUSED, 16'hFFFF);
    plan_point(30, 30);
    plan_point(10, 30);
    plan_point(50, 30);
    plan_point(30, 20);
    plan_point(30, 40);
    plan_point(7, 30);
    plan_point(13, 30);
    plan_point(-32768, -32768);
    plan_point(32767, 32767);
    plan_box(-32768, -32768, 65535, 0, 255);
    plan_point(-32768, -32768);
    plan_point(32767, -32768);
    plan_point(0, 32767);
    plan_box(32767, 32767, 0, 65535, 0);
    plan_point(32767, 32767);
    plan_point(-32768, -32768);
    plan_point(32767, -32768);
    plan_box(-100, 50, 64, 200, 0);
    plan_point(-68, 50);
    plan_point(-68, 250);
    plan_point(-100, 150);
    for (int ph = 0; ph < 13; ph++) plan_random_phase(140);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
  end

  int gap = 0;
  int quiet = 0;
  int gap_pct = 30;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    bit wr;
    wr = 0;
    if (rst_n) begin
      if (start && !busy) hit_q.push_back(hit_predict(in_point_x, in_point_y));
      quiet <= (hit_q.size() == 0 && !start) ? quiet + 1 : 0;
      if (start && busy) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (plan_q.size() == 0) begin
        start <= 0;
      end else if (!plan_q[0].is_cfg) begin
        start <= 1;
        in_point_x <= plan_q[0].px;
        in_point_y <= plan_q[0].py;
        void'(plan_q.pop_front());
        gap <= pick_gap();
      end else begin
        start <= 0;
        if (!start && hit_q.size() == 0 && quiet > LATENCY + 20) begin
          wr = 1;
          cfg_index <= plan_q[0].idx;
          cfg_data <= plan_q[0].data;
          case (plan_q[0].idx)
            eoh_pkg::REG_BOX_LEFT:   m_left <= plan_q[0].data;
            eoh_pkg::REG_BOX_TOP:    m_top <= plan_q[0].data;
            eoh_pkg::REG_BOX_WIDTH:  m_width <= plan_q[0].data;
            eoh_pkg::REG_BOX_HEIGHT: m_height <= plan_q[0].data;
            eoh_pkg::REG_HIT_TOL:    m_tol <= plan_q[0].data[7:0];
            default: ;
          endcase
          writes_done <= writes_done + 1;
          gap_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
          void'(plan_q.pop_front());
        end
      end
      cfg_wr_en <= wr;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen <= results_seen + 1;
      if (out_hit) hits_seen <= hits_seen + 1;
      if (hit_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result: hit=%0b", out_hit);
      end else begin
        if (hit_q[0] !== out_hit) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("hit mismatch: expected %0b, got %0b", hit_q[0], out_hit);
        end
        void'(hit_q.pop_front());
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (plan_q.size() == 0 && hit_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d points (%0d hits) over %0d register writes.",
             results_seen, hits_seen, writes_done);
    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d requests pending.", hit_q.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule
